FILE: hw/rtl/sprite_animation_frame_stepper_unit_macros.svh
// Assertion helpers for the frame stepper. Both sample on the rising edge of clk
// and are off while rst_n is low.
`ifndef SPRITE_ANIMATION_FRAME_STEPPER_UNIT_MACROS_SVH
`define SPRITE_ANIMATION_FRAME_STEPPER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame stepper assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SAFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame stepper assertion failed");

`endif

FILE: hw/rtl/safs_pkg.sv
`timescale 1ns / 1ps
package safs_pkg;

  // Bound on frame advances within one tick.
  localparam int FRAMES = 256;
  localparam int ADV_SAT = 511;
  localparam int CNT_W = ($clog2(FRAMES + 1) > 9) ? $clog2(FRAMES + 1) : 9;
  localparam logic [8:0] STALL_ADV = 9'((FRAMES > ADV_SAT) ? ADV_SAT : FRAMES);
  localparam logic [16:0] TIMER_MAX = 17'h1FFFF;
  localparam int STORE_DEPTH = 256;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SPEED       = 3'd0,
    REG_FRAME_COUNT = 3'd1,
    REG_LOOP_INDEX  = 3'd2,
    REG_FIXED_DUR   = 3'd3,
    REG_USE_TABLE   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CMP,
    ST_ADV,
    ST_LOAD,
    ST_RESTART,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ALU_ADD_SAT,
    ALU_SUB,
    ALU_GT
  } alu_op_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [8:0]  frame_count;
    logic [7:0]  loop_index;
    logic [15:0] fixed_duration;
    logic        use_table;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  current_frame;
    logic [16:0] timer_now;
    logic [8:0]  frames_advanced;
    logic        stalled;
  } res_t;

  // A frame count of zero acts as one, anything above the store depth as the depth.
  function automatic logic [8:0] eff_count(input logic [8:0] fc);
    logic [8:0] r;
    if (fc == 9'd0) begin
      r = 9'd1;
    end else if (fc > 9'(STORE_DEPTH)) begin
      r = 9'(STORE_DEPTH);
    end else begin
      r = fc;
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp_frame(input logic [7:0] f, input logic [8:0] fc);
    logic [8:0] last;
    last = fc - 9'd1;
    return ({1'b0, f} >= fc) ? last[7:0] : f;
  endfunction

endpackage

FILE: hw/rtl/safs_regs.sv
`timescale 1ns / 1ps
module safs_regs import safs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed          <= 16'd1;
      cfg_r.frame_count    <= 9'd1;
      cfg_r.loop_index     <= 8'd0;
      cfg_r.fixed_duration <= 16'd0;
      cfg_r.use_table      <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_SPEED:       cfg_r.speed          <= pwdata[15:0];
        REG_FRAME_COUNT: cfg_r.frame_count    <= pwdata[8:0];
        REG_LOOP_INDEX:  cfg_r.loop_index     <= pwdata[7:0];
        REG_FIXED_DUR:   cfg_r.fixed_duration <= pwdata[15:0];
        REG_USE_TABLE:   cfg_r.use_table      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPEED:       prdata = {16'd0, cfg_r.speed};
      REG_FRAME_COUNT: prdata = {23'd0, cfg_r.frame_count};
      REG_LOOP_INDEX:  prdata = {24'd0, cfg_r.loop_index};
      REG_FIXED_DUR:   prdata = {16'd0, cfg_r.fixed_duration};
      REG_USE_TABLE:   prdata = {31'd0, cfg_r.use_table};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

FILE: hw/rtl/safs_alu.sv
`timescale 1ns / 1ps
module safs_alu import safs_pkg::*; (
  input  alu_op_t     op,
  input  logic [16:0] a,
  input  logic [16:0] b,
  output logic [16:0] result,
  output logic        flag
);

  logic [16:0] b_op;
  logic        cin;
  logic [17:0] sum;

  // One adder serves all three operations. For the compare the carry out of
  // a + ~b is set exactly when a is strictly greater than b.
  always_comb begin
    case (op)
      ALU_ADD_SAT: begin
        b_op = b;
        cin  = 1'b0;
      end
      ALU_SUB: begin
        b_op = ~b;
        cin  = 1'b1;
      end
      ALU_GT: begin
        b_op = ~b;
        cin  = 1'b0;
      end
      default: begin
        b_op = b;
        cin  = 1'b0;
      end
    endcase
    sum  = {1'b0, a} + {1'b0, b_op} + {17'd0, cin};
    flag = sum[17];
    if (op == ALU_ADD_SAT && sum[17]) begin
      result = TIMER_MAX;
    end else begin
      result = sum[16:0];
    end
  end

endmodule

FILE: hw/rtl/safs_core.sv
`timescale 1ns / 1ps
module safs_core import safs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_frame_index,
  input  logic [15:0] in_duration_value,
  output logic        res_valid,
  input  logic        res_take,
  output res_t        res
);

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic [7:0]       fidx_r, fidx_nxt;
  logic [16:0]      timer_r, timer_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [15:0]      dur_r, dur_nxt;
  logic [CNT_W-1:0] adv_r, adv_nxt;
  logic             stalled_r, stalled_nxt;

  logic [15:0] mem [STORE_DEPTH];
  logic [15:0] rdata_r;
  logic [7:0]  rd_addr;
  logic        mem_we;

  alu_op_t     alu_op;
  logic [16:0] alu_b;
  logic [16:0] alu_res;
  logic        alu_flag;

  logic       accept;
  logic [8:0] fc;
  logic [7:0] loop_to;
  logic [8:0] pos_inc;
  logic [7:0] pos_next;
  logic [7:0] restart_pos;

  safs_alu u_alu (
    .op     (alu_op),
    .a      (timer_r),
    .b      (alu_b),
    .result (alu_res),
    .flag   (alu_flag)
  );

  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid & in_ready;
  assign mem_we      = accept && (cmd_t'(in_cmd) == CMD_WRITE);
  assign fc          = eff_count(cfg.frame_count);
  assign loop_to     = clamp_frame(cfg.loop_index, fc);
  assign pos_inc     = {1'b0, pos_r} + 9'd1;
  assign pos_next    = (pos_inc >= fc) ? loop_to : pos_inc[7:0];
  assign restart_pos = clamp_frame(fidx_r, fc);
  assign rd_addr     = (state_r == ST_RESTART) ? restart_pos : pos_next;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_frame_index] <= in_duration_value;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      timer_r <= 17'd0;
      pos_r   <= 8'd0;
      dur_r   <= 16'd0;
    end else begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
      pos_r   <= pos_nxt;
      dur_r   <= dur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    fidx_r    <= fidx_nxt;
    adv_r     <= adv_nxt;
    stalled_r <= stalled_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    fidx_nxt    = fidx_r;
    timer_nxt   = timer_r;
    pos_nxt     = pos_r;
    dur_nxt     = dur_r;
    adv_nxt     = adv_r;
    stalled_nxt = stalled_r;
    alu_op      = ALU_GT;
    alu_b       = {1'b0, dur_r};
    res_valid   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt     = cmd_t'(in_cmd);
          fidx_nxt    = in_frame_index;
          adv_nxt     = '0;
          stalled_nxt = 1'b0;
          case (cmd_t'(in_cmd))
            CMD_TICK:    state_nxt = ST_ADD;
            CMD_RESTART: state_nxt = ST_RESTART;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD: begin
        alu_op    = ALU_ADD_SAT;
        alu_b     = {1'b0, cfg.speed};
        timer_nxt = alu_res;
        if (!cfg.use_table) begin
          dur_nxt = cfg.fixed_duration;
        end
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        alu_op = ALU_GT;
        if (alu_flag && (adv_r < CNT_W'(FRAMES))) begin
          state_nxt = ST_ADV;
        end else begin
          // Leaving with the timer still above the duration means the bound was hit.
          stalled_nxt = alu_flag;
          state_nxt   = ST_DONE;
        end
      end
      ST_ADV: begin
        alu_op    = ALU_SUB;
        timer_nxt = alu_res;
        pos_nxt   = pos_next;
        adv_nxt   = adv_r + CNT_W'(1);
        state_nxt = cfg.use_table ? ST_LOAD : ST_CMP;
      end
      ST_LOAD: begin
        dur_nxt   = rdata_r;
        state_nxt = (cmd_r == CMD_RESTART) ? ST_DONE : ST_CMP;
      end
      ST_RESTART: begin
        pos_nxt   = restart_pos;
        timer_nxt = 17'd0;
        if (cfg.use_table) begin
          state_nxt = ST_LOAD;
        end else begin
          dur_nxt   = cfg.fixed_duration;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign res.current_frame   = pos_r;
  assign res.timer_now       = timer_r;
  assign res.frames_advanced = (adv_r > CNT_W'(ADV_SAT)) ? 9'(ADV_SAT) : adv_r[8:0];
  assign res.stalled         = stalled_r;

endmodule

FILE: hw/rtl/sprite_animation_frame_stepper_unit.sv
// Steps: a table write or unused command goes from accept straight to DONE; a restart
// passes RESTART (then LOAD in table mode); a tick passes ADD and CMP, then ADV (and
// LOAD in table mode) and CMP again for each of N frame advances, N at most FRAMES.
// Throughput: one item at a time; the next item can be accepted in the cycle after the
// previous result moves into the output register.
// Reset (rst_n low, synchronous): timer, frame and duration go to zero and the
// registers to their defaults; the duration store is not cleared.
`timescale 1ns / 1ps
`include "sprite_animation_frame_stepper_unit_macros.svh"
module sprite_animation_frame_stepper_unit import safs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_frame_index,
  input  logic [15:0] in_duration_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_current_frame,
  output logic [16:0] out_timer_now,
  output logic [8:0]  out_frames_advanced,
  output logic        out_stalled,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  res_t res;
  res_t out_res_r;
  logic out_valid_r;
  logic res_valid;
  logic res_take;
  logic in_ready;

  safs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  safs_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_frame_index    (in_frame_index),
    .in_duration_value (in_duration_value),
    .res_valid         (res_valid),
    .res_take          (res_take),
    .res               (res)
  );

  // The output register frees the core as soon as a finished item is handed over.
  assign res_take = !out_valid_r || !out_stall;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_current_frame   = out_res_r.current_frame;
  assign out_timer_now       = out_res_r.timer_now;
  assign out_frames_advanced = out_res_r.frames_advanced;
  assign out_stalled         = out_res_r.stalled;

  `SAFS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `SAFS_ASSERT_NOW(a_stall_at_bound, out_valid && out_stalled, out_frames_advanced == STALL_ADV)
  `SAFS_ASSERT_NOW(a_stall_timer_set, out_valid && out_stalled, out_timer_now != 17'd0)

endmodule

FILE: tb/tb_sprite_animation_frame_stepper_unit.sv
`timescale 1ns / 1ps
module tb_sprite_animation_frame_stepper_unit;
  import safs_pkg::*;

  localparam int IDLE_LIMIT = 8000;
  localparam int RANDOM_ITEMS = 1850;

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  idx;
    logic [15:0] dur;
  } sprite_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = 2'd0;
  logic [7:0]  in_frame_index = 8'd0;
  logic [15:0] in_duration_value = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_current_frame;
  logic [16:0] out_timer_now;
  logic [8:0]  out_frames_advanced;
  logic        out_stalled;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  sprite_animation_frame_stepper_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_frame_index     (in_frame_index),
    .in_duration_value  (in_duration_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_frame  (out_current_frame),
    .out_timer_now      (out_timer_now),
    .out_frames_advanced(out_frames_advanced),
    .out_stalled        (out_stalled),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #5 clk = ~clk;

  // Mirror of the block's registers and animation state.
  cfg_t        cfg_mirror = '{speed: 16'd1, frame_count: 9'd1, loop_index: 8'd0,
                              fixed_duration: 16'd0, use_table: 1'b1};
  logic [16:0] anim_timer = '0;
  logic [7:0]  anim_frame = '0;
  logic [15:0] anim_dur = '0;
  logic [15:0] dur_table [STORE_DEPTH];

  sprite_cmd_t cmd_backlog [$];
  res_t        due_frames [$];
  sprite_cmd_t cur_cmd;

  int cmds_queued = 0;
  int driven_items = 0;
  int results_seen = 0;
  int fail_count = 0;
  int bound_hits = 0;
  int most_advances = 0;
  int settings_used = 0;
  int send_gap = 0;
  int send_quiet = 0;
  int hold_left = 0;
  int recv_quiet = 0;
  int big_holds = 0;
  int idle_cycles = 0;

  function automatic int frame_limit();
    if (cfg_mirror.frame_count == 9'd0) return 1;
    if (cfg_mirror.frame_count > 9'd256) return 256;
    return int'(cfg_mirror.frame_count);
  endfunction

  function automatic logic [7:0] fit_frame(input logic [7:0] f);
    int fc;
    fc = frame_limit();
    return (int'(f) >= fc) ? 8'(fc - 1) : f;
  endfunction

  // Applies one item to the mirrored state and returns the result it should produce.
  function automatic res_t sprite_step(input sprite_cmd_t it);
    res_t        r;
    int unsigned t;
    int unsigned nxt;
    int          n;
    int          fc;
    logic [7:0]  wrap_to;
    n = 0;
    r.stalled = 1'b0;
    fc = frame_limit();
    case (it.cmd)
      CMD_TICK: begin
        wrap_to = fit_frame(cfg_mirror.loop_index);
        t = anim_timer + cfg_mirror.speed;
        if (t > TIMER_MAX) t = TIMER_MAX;
        if (!cfg_mirror.use_table) anim_dur = cfg_mirror.fixed_duration;
        while (t > anim_dur && n < FRAMES) begin
          t -= anim_dur;
          nxt = anim_frame + 1;
          anim_frame = (nxt >= fc) ? wrap_to : 8'(nxt);
          if (cfg_mirror.use_table) anim_dur = dur_table[anim_frame];
          n++;
        end
        r.stalled = (t > anim_dur);
        anim_timer = 17'(t);
      end
      CMD_WRITE: begin
        dur_table[it.idx] = it.dur;
      end
      CMD_RESTART: begin
        anim_frame = fit_frame(it.idx);
        anim_timer = '0;
        anim_dur = cfg_mirror.use_table ? dur_table[anim_frame] : cfg_mirror.fixed_duration;
      end
      default: begin
      end
    endcase
    r.current_frame = anim_frame;
    r.timer_now = anim_timer;
    r.frames_advanced = (n > ADV_SAT) ? 9'(ADV_SAT) : 9'(n);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none at all.
  function automatic int draw_gap(inout int quiet);
    int roll;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) quiet = $urandom_range(20, 80);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic void queue_cmd(input cmd_t c, input logic [7:0] idx, input logic [15:0] dur);
    sprite_cmd_t it;
    it.cmd = c;
    it.idx = idx;
    it.dur = dur;
    cmd_backlog.push_back(it);
    cmds_queued++;
    driven_items++;
  endfunction

  function automatic logic [15:0] pick_dur(input int unsigned dmax, input bit no_zero);
    if (!no_zero && $urandom_range(0, 23) == 0) return 16'd0;
    return 16'($urandom_range(1, dmax));
  endfunction

  task automatic reg_write(input reg_idx_t r, input logic [31:0] d);
    logic [31:0] rd;
    logic [31:0] mask;
    case (r)
      REG_FRAME_COUNT: mask = 32'h1FF;
      REG_LOOP_INDEX:  mask = 32'hFF;
      REG_USE_TABLE:   mask = 32'h1;
      default:         mask = 32'hFFFF;
    endcase
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_SPEED:       cfg_mirror.speed = d[15:0];
      REG_FRAME_COUNT: cfg_mirror.frame_count = d[8:0];
      REG_LOOP_INDEX:  cfg_mirror.loop_index = d[7:0];
      REG_FIXED_DUR:   cfg_mirror.fixed_duration = d[15:0];
      default:         cfg_mirror.use_table = d[0];
    endcase
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) !== (d & mask)) begin
      $error("register %s: expected %0h, got %0h", r.name(), d & mask, rd & mask);
      fail_count++;
    end
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] spd, input logic [8:0] fc, input logic [7:0] lp,
                           input logic [15:0] fx, input logic ut);
    reg_write(REG_SPEED, 32'(spd));
    reg_write(REG_FRAME_COUNT, 32'(fc));
    reg_write(REG_LOOP_INDEX, 32'(lp));
    reg_write(REG_FIXED_DUR, 32'(fx));
    reg_write(REG_USE_TABLE, 32'(ut));
    settings_used++;
    @(negedge clk);
  endtask

  // The sender holds back here until every item handed over has produced its result.
  task automatic drain();
    while (results_seen < cmds_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_frames.push_back(sprite_step(cur_cmd));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cur_cmd = cmd_backlog.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_cmd.cmd;
          in_frame_index <= cur_cmd.idx;
          in_duration_value <= cur_cmd.dur;
          send_gap = draw_gap(send_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_frames.size() == 0) begin
          $error("result arrived with no item outstanding");
          fail_count++;
        end else begin
          want = due_frames.pop_front();
          if (out_current_frame !== want.current_frame) begin
            $error("current_frame: expected %0d, got %0d", want.current_frame, out_current_frame);
            fail_count++;
          end
          if (out_timer_now !== want.timer_now) begin
            $error("timer_now: expected %0d, got %0d", want.timer_now, out_timer_now);
            fail_count++;
          end
          if (out_frames_advanced !== want.frames_advanced) begin
            $error("frames_advanced: expected %0d, got %0d", want.frames_advanced,
                   out_frames_advanced);
            fail_count++;
          end
          if (out_stalled !== want.stalled) begin
            $error("stalled: expected %0d, got %0d", want.stalled, out_stalled);
            fail_count++;
          end
          if (want.stalled) bound_hits++;
          if (int'(want.frames_advanced) > most_advances) begin
            most_advances = int'(want.frames_advanced);
          end
        end
      end
      // Twice in the run the receiver stops for a long stretch so the input backs up.
      if (hold_left == 0 && big_holds < 2 && results_seen >= 400 + 900 * big_holds) begin
        hold_left = 300;
        big_holds++;
      end else if (hold_left == 0) begin
        hold_left = draw_gap(recv_quiet);
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int          base;
    int          fc_eff;
    int          loop_eff;
    int          n_items;
    int          roll;
    int unsigned dmax;
    logic        ut;
    logic [8:0]  fc_reg;
    logic [7:0]  lp;
    logic [7:0]  idx;
    logic [15:0] spd;
    logic [15:0] fx;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Settings after reset: one frame, table mode, current and fixed duration zero.
    queue_cmd(CMD_NONE, 8'hFF, 16'hFFFF);
    queue_cmd(CMD_WRITE, 8'h00, 16'h0000);
    queue_cmd(CMD_WRITE, 8'hFF, 16'hFFFF);
    queue_cmd(CMD_WRITE, 8'h55, 16'hAAAA);
    queue_cmd(CMD_TICK, 8'h00, 16'h0000);
    queue_cmd(CMD_RESTART, 8'hC8, 16'h0000);
    drain();

    // Fixed mode with zero duration: every tick hits the bound and the timer saturates.
    configure(16'hFFFF, 9'h1FF, 8'hFF, 16'h0000, 1'b0);
    repeat (3) queue_cmd(CMD_TICK, 8'h00, 16'h0000);
    queue_cmd(CMD_RESTART, 8'hFF, 16'h0000);
    queue_cmd(CMD_NONE, 8'h00, 16'h0000);
    drain();

    // Frame count of zero acts as one frame.
    configure(16'hFFFF, 9'd0, 8'd0, 16'hFFFF, 1'b0);
    queue_cmd(CMD_TICK, 8'h00, 16'h0000);
    queue_cmd(CMD_TICK, 8'h00, 16'h0000);
    queue_cmd(CMD_RESTART, 8'd7, 16'h0000);
    drain();

    // Table mode, loop index beyond the last frame.
    configure(16'd7, 9'd5, 8'd200, 16'd0, 1'b1);
    queue_cmd(CMD_WRITE, 8'd0, 16'd3);
    queue_cmd(CMD_WRITE, 8'd1, 16'd0);
    queue_cmd(CMD_WRITE, 8'd2, 16'd9);
    queue_cmd(CMD_WRITE, 8'd3, 16'd2);
    queue_cmd(CMD_WRITE, 8'd4, 16'd5);
    repeat (4) queue_cmd(CMD_TICK, 8'h00, 16'h0000);
    queue_cmd(CMD_RESTART, 8'd3, 16'h0000);
    queue_cmd(CMD_RESTART, 8'd250, 16'h0000);
    queue_cmd(CMD_TICK, 8'h00, 16'h0000);
    drain();

    base = driven_items;
    while (driven_items - base < RANDOM_ITEMS) begin
      ut = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 9);
      if (roll < 6) fc_reg = 9'($urandom_range(1, 8));
      else if (roll < 8) fc_reg = 9'($urandom_range(9, 64));
      else if (roll < 9) fc_reg = 9'($urandom_range(65, 256));
      else fc_reg = 9'($urandom_range(0, 511));
      fc_eff = (fc_reg == 9'd0) ? 1 : (fc_reg > 9'd256) ? 256 : int'(fc_reg);
      lp = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, fc_eff - 1));
      loop_eff = (int'(lp) >= fc_eff) ? fc_eff - 1 : int'(lp);
      case ($urandom_range(0, 3))
        0:       dmax = 15;
        1:       dmax = 255;
        2:       dmax = 4095;
        default: dmax = 65535;
      endcase
      spd = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, dmax));
      fx = 16'($urandom_range(1, dmax));
      configure(spd, fc_reg, lp, fx, ut);

      // Every frame the animation can reach gets a duration before any tick reads one.
      // The loop frame never gets zero, so the animation cannot get stuck hitting the bound.
      if (ut) begin
        for (int i = 0; i < fc_eff; i++) queue_cmd(CMD_WRITE, 8'(i), pick_dur(dmax, i == loop_eff));
      end
      queue_cmd(CMD_RESTART, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      n_items = $urandom_range(100, 180);
      repeat (n_items) begin
        roll = $urandom_range(0, 99);
        idx = 8'($urandom_range(0, 255));
        if (roll < 62) begin
          queue_cmd(CMD_TICK, idx, 16'($urandom_range(0, 65535)));
        end else if (roll < 77) begin
          queue_cmd(CMD_WRITE, idx, pick_dur(dmax, int'(idx) == loop_eff));
        end else if (roll < 90) begin
          if ($urandom_range(0, 1)) idx = 8'($urandom_range(0, fc_eff - 1));
          queue_cmd(CMD_RESTART, idx, 16'($urandom_range(0, 65535)));
        end else begin
          queue_cmd(CMD_NONE, idx, 16'($urandom_range(0, 65535)));
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Drove %0d items over %0d register settings and checked %0d results.",
             driven_items, settings_used, results_seen);
    $display("%0d ticks hit the advance bound; the largest advance count was %0d.",
             bound_hits, most_advances);
    if (fail_count == 0 && due_frames.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/safs_pkg.sv
hw/rtl/safs_regs.sv
hw/rtl/safs_alu.sv
hw/rtl/safs_core.sv
hw/rtl/sprite_animation_frame_stepper_unit.sv
tb/tb_sprite_animation_frame_stepper_unit.sv
